[hdl/dhcpu_pkg.sv]
// ----------------------------------------------------------------------------
// dhcpu_pkg
// Shared constants for the DHCP ACK prefix utilization monitor.
// ----------------------------------------------------------------------------
package dhcpu_pkg;

  localparam int NUM_PREFIXES  = 4;
  localparam int SEEN_DEPTH    = 1024;
  localparam int POSITION_BITS = 16;
  localparam int SEEN_AW       = $clog2(SEEN_DEPTH);
  localparam int FILL_W        = SEEN_AW + 1;
  localparam int PIDX_W        = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1;
  localparam int USED_W        = $clog2(NUM_PREFIXES + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [30:0] COUNT_MAX = 31'd2147483646;
  localparam logic [31:0] COOKIE    = 32'd1669485411;
  localparam logic [15:0] BOOTPS    = 16'd67;
  localparam logic [7:0]  OPT_MSG   = 8'd53;
  localparam logic [7:0]  MSG_ACK   = 8'd5;

  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_USED   = 3'd1;
  localparam logic [2:0] REG_PFX0   = 3'd2;
  localparam logic [2:0] REG_PFX3   = 3'd5;

  localparam logic [1:0] OPH_TYPE = 2'd0;
  localparam logic [1:0] OPH_LEN  = 2'd1;
  localparam logic [1:0] OPH_LEN53 = 2'd2;
  localparam logic [1:0] OPH_VAL  = 2'd3;

  localparam int OUT_W = 72;

endpackage

[hdl/dhcp_ack_prefix_utilization.sv]
// ----------------------------------------------------------------------------
// dhcp_ack_prefix_utilization
// Parses frames for DHCP ACKs and tracks per-prefix address utilization.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per request, tdata = frame_byte, tlast = frame end.
//   cfg_* : register writes (index, data), only while the block is idle.
//   out_* : at frame end, one request per prefix in use; tlast marks the last.
// Throughput: one byte per cycle while a frame streams. At frame end with a
// valid ACK, the seen-address memory is searched one entry at a time
// (address, read wait, compare) until a hit or the fill count, then the
// search finishes and the address is stored. Each prefix in use then goes
// through count memory read, read wait, update and multiply, alert check
// and emit. A frame end without ACK skips the search and takes the same
// steps for each prefix. Input reopens the cycle after the last result is
// taken.
// Reset clears parse state, fill count, count valid bits and alert bits at
// once; the seen memory needs no clearing since only entries below the fill
// are read. A stalled receiver holds the result; input waits until all
// results of the frame are taken.
// ----------------------------------------------------------------------------
module dhcp_ack_prefix_utilization (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [37:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] prefix_index, [32:2] allocated_count, [33] counted_now,
  // [34] alert_now, [35] ack_seen, [36] new_address, [68:37] given_address,
  // [69] seen_table_full, [71:70] zero
  output logic [71:0] out_tdata,
  output logic        out_tlast   // last_result
);

  localparam int PW = dhcpu_pkg::POSITION_BITS;
  localparam int AW = dhcpu_pkg::SEEN_AW;
  localparam int FW = dhcpu_pkg::FILL_W;
  localparam int IW = dhcpu_pkg::PIDX_W;
  localparam int UW = dhcpu_pkg::USED_W;
  localparam int NP = dhcpu_pkg::NUM_PREFIXES;
  localparam int NR = (NP < 4) ? NP : 4;

  typedef enum logic [3:0] {
    ST_PARSE, ST_SRCH, ST_SWAIT, ST_SCMP, ST_STORE,
    ST_PRD, ST_PWAIT, ST_PMUL, ST_PCHK, ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic        offset_r;
  logic [2:0]  used_cfg_r;
  logic [37:0] pfx_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= 1'b0;
      used_cfg_r <= '0;
      for (int i = 0; i < 4; i++) pfx_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dhcpu_pkg::REG_OFFSET: offset_r <= cfg_data[0];
        dhcpu_pkg::REG_USED:   used_cfg_r <= cfg_data[2:0];
        default: begin
          if (cfg_index inside {[dhcpu_pkg::REG_PFX0 : dhcpu_pkg::REG_PFX3]})
            pfx_r[2'(cfg_index - dhcpu_pkg::REG_PFX0)] <= cfg_data;
        end
      endcase
    end
  end

  // parser state
  logic [PW-1:0] pos_r, nop_r;
  logic [5:0]    ihl_r;
  logic          hv_r, ack_r;
  logic [15:0]   port_r;
  logic [31:0]   addr_r, cookie_r;
  logic [1:0]    oph_r;

  logic [PW-1:0] pos_nxt, nop_nxt;
  logic [5:0]    ihl_nxt;
  logic          hv_nxt, ack_nxt;
  logic [15:0]   port_nxt;
  logic [31:0]   addr_nxt, cookie_nxt;
  logic [1:0]    oph_nxt;

  logic [16:0] hdr, hx;
  logic [16:0] p17;
  logic [7:0]  b;
  logic [17:0] nx;

  assign b   = in_tdata;
  assign hdr = 17'd14 + {15'd0, offset_r, 1'b0};
  assign hx  = hdr + {11'd0, ihl_r};
  assign p17 = 17'(pos_r);

  always_comb begin
    pos_nxt = pos_r; nop_nxt = nop_r; ihl_nxt = ihl_r; hv_nxt = hv_r;
    ack_nxt = ack_r; port_nxt = port_r; addr_nxt = addr_r;
    cookie_nxt = cookie_r; oph_nxt = oph_r;
    nx = 18'(p17) + 18'd1 + 18'(b);
    if (pos_r != dhcpu_pkg::POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
      if (p17 == hdr) begin
        if (b[7:4] == 4'd4 && b[3:0] != 4'd0) begin
          hv_nxt  = 1'b1;
          ihl_nxt = {b[3:0], 2'b00};
          nop_nxt = PW'(hdr + {11'd0, b[3:0], 2'b00} + 17'd248);
          oph_nxt = dhcpu_pkg::OPH_TYPE;
        end
      end else if (hv_r && p17 > hdr) begin
        if (p17 == hx) begin
          port_nxt = {8'd0, b};
        end else if (p17 == hx + 17'd1) begin
          port_nxt = {port_r[7:0], b};
          if ({port_r[7:0], b} != dhcpu_pkg::BOOTPS) hv_nxt = 1'b0;
        end else if (p17 >= hx + 17'd24 && p17 <= hx + 17'd27) begin
          addr_nxt = {addr_r[23:0], b};
        end else if (p17 >= hx + 17'd244 && p17 <= hx + 17'd247) begin
          cookie_nxt = {cookie_r[23:0], b};
          if (p17 == hx + 17'd247 && {cookie_r[23:0], b} != dhcpu_pkg::COOKIE)
            hv_nxt = 1'b0;
        end else if (p17 >= hx + 17'd248 && !ack_r) begin
          if (oph_r == dhcpu_pkg::OPH_VAL) begin
            if (b == dhcpu_pkg::MSG_ACK) ack_nxt = 1'b1;
            oph_nxt = dhcpu_pkg::OPH_TYPE;
          end
          if (!ack_nxt) begin
            if (oph_nxt == dhcpu_pkg::OPH_TYPE) begin
              if (pos_r == nop_r)
                oph_nxt = (b == dhcpu_pkg::OPT_MSG) ? dhcpu_pkg::OPH_LEN53
                                                     : dhcpu_pkg::OPH_LEN;
            end else begin
              nop_nxt = (nx > 18'(dhcpu_pkg::POS_MAX)) ? dhcpu_pkg::POS_MAX : PW'(nx);
              oph_nxt = (oph_nxt == dhcpu_pkg::OPH_LEN53) ? dhcpu_pkg::OPH_VAL
                                                           : dhcpu_pkg::OPH_TYPE;
            end
          end
        end
      end
    end
  end

  // seen memory
  logic [31:0]   seen_mem [dhcpu_pkg::SEEN_DEPTH];
  logic [31:0]   seen_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [FW-1:0] fill_r, idx_r;
  logic [31:0]   given_r;

  always_ff @(posedge clk) begin
    if (wr_en) seen_mem[fill_r[AW-1:0]] <= given_r;
    seen_q <= seen_mem[rd_addr];
  end

  // count memory (one entry per prefix), alert bits in flops
  logic [30:0] cnt_mem [NP];
  logic [30:0] cnt_q;
  logic [NP-1:0] cvalid_r, alerted_r;
  logic        cnt_we;
  logic [30:0] cnt_wd;
  logic [IW-1:0] pi_r;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[pi_r] <= cnt_wd;
    cnt_q <= cnt_mem[pi_r];
  end

  // frame-end latches
  logic        acks_r, fresh_r, full_r, found_r;
  logic [UW-1:0] used_r;
  logic [30:0] cnt_r;
  logic        counted_r, alert_r, match_r;
  logic [31:0] hosts_r;
  logic [63:0] lhs_r, rhs_r;

  // prefix match on current prefix index
  logic [37:0] preg;
  logic [5:0]  plen;
  logic [5:0]  hbits;
  logic [31:0] mask, host;
  logic        pmatch;
  always_comb begin
    preg  = pfx_r[2'(pi_r)];
    plen  = preg[37:32];
    hbits = 6'd32 - plen;
    mask  = (32'd1 << hbits[4:0]) - 32'd1;
    host  = given_r & mask;
    pmatch = (plen >= 6'd1) && (plen <= 6'd30) && (host != 32'd0) && (host != mask)
             && ((given_r & ~mask) == (preg[31:0] & ~mask));
  end

  logic [31:0] given_w;
  logic [16:0] end_pos;
  logic [30:0] cur_cnt;
  logic        alert_hit;
  assign end_pos = 17'(pos_nxt);
  assign given_w = (end_pos >= hdr + {11'd0, ihl_nxt} + 17'd28 && ihl_nxt != 6'd0)
                   ? addr_nxt : 32'd0;
  assign cur_cnt = cvalid_r[pi_r] ? cnt_q : 31'd0;
  assign rd_addr = idx_r[AW-1:0];
  assign wr_en   = (state_r == ST_STORE) && !found_r && !fill_r[FW-1];
  assign cnt_we  = (state_r == ST_PMUL) && match_r;
  assign cnt_wd  = (cur_cnt < dhcpu_pkg::COUNT_MAX) ? cur_cnt + 31'd1 : cur_cnt;
  assign alert_hit = counted_r && !alerted_r[pi_r] && (lhs_r >= rhs_r);

  assign in_tready  = (state_r == ST_PARSE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tlast  = (UW'(pi_r) + 1'b1 == used_r);
  assign out_tdata  = {2'b00, full_r, given_r, fresh_r, acks_r, alert_r,
                       counted_r, cnt_r, 2'(pi_r)};

  logic [2:0] used_clamp;
  assign used_clamp = (used_cfg_r > 3'(NR)) ? 3'(NR) : used_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PARSE;
      pos_r <= '0; nop_r <= '0; ihl_r <= '0; hv_r <= 1'b0; ack_r <= 1'b0;
      port_r <= '0; addr_r <= '0; cookie_r <= '0; oph_r <= '0;
      fill_r <= '0; idx_r <= '0; cvalid_r <= '0; alerted_r <= '0;
      pi_r <= '0; found_r <= 1'b0;
    end else begin
      case (state_r)
        ST_PARSE: begin
          if (in_tvalid) begin
            if (in_tlast) begin
              given_r <= given_w;
              acks_r  <= hv_nxt && ack_nxt;
              used_r  <= UW'(used_clamp);
              fresh_r <= 1'b0; full_r <= 1'b0; found_r <= 1'b0;
              idx_r   <= '0; pi_r <= '0;
              pos_r <= '0; nop_r <= '0; ihl_r <= '0; hv_r <= 1'b0; ack_r <= 1'b0;
              port_r <= '0; addr_r <= '0; cookie_r <= '0; oph_r <= '0;
              if (hv_nxt && ack_nxt) state_r <= ST_SRCH;
              else if (used_clamp != 3'd0) state_r <= ST_PRD;
            end else begin
              pos_r <= pos_nxt; nop_r <= nop_nxt; ihl_r <= ihl_nxt; hv_r <= hv_nxt;
              ack_r <= ack_nxt; port_r <= port_nxt; addr_r <= addr_nxt;
              cookie_r <= cookie_nxt; oph_r <= oph_nxt;
            end
          end
        end
        ST_SRCH: begin
          if (idx_r >= fill_r) state_r <= ST_STORE;
          else state_r <= ST_SWAIT;
        end
        ST_SWAIT: state_r <= ST_SCMP;
        ST_SCMP: begin
          if (seen_q == given_r) begin
            found_r <= 1'b1;
            state_r <= ST_STORE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_SRCH;
          end
        end
        ST_STORE: begin
          if (!found_r) begin
            fresh_r <= 1'b1;
            if (fill_r[FW-1]) full_r <= 1'b1;
            else fill_r <= fill_r + 1'b1;
          end
          state_r <= (used_r != '0) ? ST_PRD : ST_PARSE;
        end
        ST_PRD: begin
          match_r <= fresh_r && pmatch;
          hosts_r <= mask - 32'd1;
          state_r <= ST_PWAIT;
        end
        ST_PWAIT: state_r <= ST_PMUL;
        ST_PMUL: begin
          cnt_r     <= match_r ? cnt_wd : cur_cnt;
          counted_r <= match_r;
          if (match_r) cvalid_r[pi_r] <= 1'b1;
          lhs_r <= 64'(cnt_wd) * 64'd20000;
          rhs_r <= 64'(hosts_r) * 64'd9999;
          state_r <= ST_PCHK;
        end
        ST_PCHK: begin
          alert_r <= alert_hit;
          if (alert_hit) alerted_r[pi_r] <= 1'b1;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_tready) begin
            if (out_tlast) state_r <= ST_PARSE;
            else begin
              pi_r    <= pi_r + 1'b1;
              state_r <= ST_PRD;
            end
          end
        end
        default: state_r <= ST_PARSE;
      endcase
    end
  end

endmodule

[hdl/dhcpu_checker.sv]
// ----------------------------------------------------------------------------
// dhcpu_checker
// Port-level checks for the DHCP ACK prefix utilization monitor.
// ----------------------------------------------------------------------------
module dhcpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // no input taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open during results");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");

  // alert only on a counted address
  a_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[33] && out_tdata[36])
    else $error("alert without count");

  // counted implies a fresh ack
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[35] && out_tdata[36])
    else $error("count without new ack");

endmodule

bind dhcp_ack_prefix_utilization dhcpu_checker u_dhcpu_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

[sim/tb_dhcp_ack_prefix_utilization.sv]
// ----------------------------------------------------------------------------
// tb_dhcp_ack_prefix_utilization
// Streams Ethernet frames into the DHCP ACK prefix monitor and checks every
// per-prefix report against an in-bench model of the parser, the seen-address
// table and the prefix counters. Register settings change between phases.
// ----------------------------------------------------------------------------
module tb_dhcp_ack_prefix_utilization;

  typedef struct packed {
    logic [1:0]  pidx;
    logic [30:0] count;
    logic        counted;
    logic        alert;
    logic        ack;
    logic        fresh;
    logic [31:0] given;
    logic        full;
    logic        last;
  } report_t;

  typedef struct packed {
    logic [7:0] octet;
    logic       eof;
  } octet_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = 0;
  logic        in_tlast = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [37:0] cfg_data = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  dhcp_ack_prefix_utilization DUT (.*);

  initial forever #5 clk = ~clk;

  // model registers and state
  logic        m_off = 0;
  logic [2:0]  m_used = 0;
  logic [37:0] m_pfx [4] = '{default: '0};
  int unsigned pos = 0, ihb = 0, next_opt = 0;
  logic        hdr_ok = 0, ack_flag = 0;
  logic [15:0] port_sh = 0;
  logic [31:0] addr_sh = 0, cookie_sh = 0;
  logic [1:0]  oph = dhcpu_pkg::OPH_TYPE;
  logic [31:0] seen [dhcpu_pkg::SEEN_DEPTH];
  int unsigned seen_fill = 0;
  int unsigned pfx_count [4] = '{default: 0};
  bit          pfx_alerted [4] = '{default: 0};

  report_t     report_q [$];
  octet_t      pend_q [$];
  logic [7:0]  opt_buf [$];
  logic [31:0] acked [$];
  int          errors = 0;
  bit          calm = 0, in_fire = 0, cfg_fire = 0;
  int          in_gap = 0, out_hold = 0;
  int unsigned cycles = 0;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit prefix_holds(logic [31:0] ip, logic [37:0] reg_v,
                                      output longint unsigned hosts);
    int unsigned len, h;
    logic [31:0] mask;
    len = int'(reg_v[37:32]);
    hosts = 0;
    if (len < 1 || len > 30) return 0;
    h = 32 - len;
    mask = (32'd1 << h) - 1;
    hosts = mask - 1;
    if ((ip & mask) == 0 || (ip & mask) == mask) return 0;
    return (ip >> h) == (reg_v[31:0] >> h);
  endfunction

  task automatic parse_octet(input logic [7:0] b);
    int unsigned p, hdr, x, nx;
    p = pos;
    hdr = 14 + 2 * m_off;
    x = ihb;
    if (p >= int'(dhcpu_pkg::POS_MAX)) return;
    pos = p + 1;
    if (p == hdr) begin
      if (b[7:4] == 4 && b[3:0] != 0) begin
        hdr_ok = 1;
        ihb = b[3:0] * 4;
        next_opt = hdr + ihb + 248;
        oph = dhcpu_pkg::OPH_TYPE;
      end
      return;
    end
    if (!hdr_ok || p < hdr) return;
    if (p == hdr + x) begin
      port_sh = {8'd0, b};
    end else if (p == hdr + x + 1) begin
      port_sh = {port_sh[7:0], b};
      if (port_sh != dhcpu_pkg::BOOTPS) hdr_ok = 0;
    end else if (p >= hdr + x + 24 && p <= hdr + x + 27) begin
      addr_sh = {addr_sh[23:0], b};
    end else if (p >= hdr + x + 244 && p <= hdr + x + 247) begin
      cookie_sh = {cookie_sh[23:0], b};
      if (p == hdr + x + 247 && cookie_sh != dhcpu_pkg::COOKIE) hdr_ok = 0;
    end else if (p >= hdr + x + 248 && !ack_flag) begin
      if (oph == dhcpu_pkg::OPH_VAL) begin
        if (b == dhcpu_pkg::MSG_ACK) ack_flag = 1;
        oph = dhcpu_pkg::OPH_TYPE;
      end
      if (!ack_flag) begin
        if (oph == dhcpu_pkg::OPH_TYPE) begin
          if (p == next_opt)
            oph = (b == dhcpu_pkg::OPT_MSG) ? dhcpu_pkg::OPH_LEN53 : dhcpu_pkg::OPH_LEN;
        end else begin
          nx = p + 1 + b;
          next_opt = nx > int'(dhcpu_pkg::POS_MAX) ? int'(dhcpu_pkg::POS_MAX) : nx;
          oph = (oph == dhcpu_pkg::OPH_LEN53) ? dhcpu_pkg::OPH_VAL : dhcpu_pkg::OPH_TYPE;
        end
      end
    end
  endtask

  // one accepted byte; at frame end the per-prefix reports are queued
  task automatic predict_octet(input logic [7:0] b, input logic eof);
    int unsigned hdr, used;
    logic [31:0] given;
    bit ack, fresh, full, found, cnt [4], alr [4];
    longint unsigned hosts;
    report_t r;
    parse_octet(b);
    if (!eof) return;
    hdr = 14 + 2 * m_off;
    given = (pos >= hdr + ihb + 28 && ihb != 0) ? addr_sh : 32'd0;
    ack = hdr_ok && ack_flag;
    used = (m_used < dhcpu_pkg::NUM_PREFIXES) ? m_used : dhcpu_pkg::NUM_PREFIXES;
    fresh = 0; full = 0; found = 0;
    cnt = '{default: 0}; alr = '{default: 0};
    if (ack) begin
      for (int i = 0; i < seen_fill; i++)
        if (seen[i] == given) found = 1;
      if (!found) begin
        fresh = 1;
        if (seen_fill < dhcpu_pkg::SEEN_DEPTH) begin
          seen[seen_fill] = given;
          seen_fill++;
        end else full = 1;
        for (int i = 0; i < used; i++) begin
          if (prefix_holds(given, m_pfx[i], hosts)) begin
            if (pfx_count[i] < dhcpu_pkg::COUNT_MAX) pfx_count[i]++;
            cnt[i] = 1;
            if (!pfx_alerted[i] && 64'd20000 * pfx_count[i] >= 64'd9999 * hosts) begin
              pfx_alerted[i] = 1;
              alr[i] = 1;
            end
          end
        end
      end
    end
    for (int i = 0; i < used; i++) begin
      r.pidx = 2'(i); r.count = 31'(pfx_count[i]); r.counted = cnt[i];
      r.alert = alr[i]; r.ack = ack; r.fresh = fresh; r.given = given; r.full = full;
      r.last = (i + 1 == used);
      report_q.push_back(r);
    end
    pos = 0; ihb = 0; hdr_ok = 0; port_sh = 0; addr_sh = 0; cookie_sh = 0;
    next_opt = 0; oph = dhcpu_pkg::OPH_TYPE; ack_flag = 0;
  endtask

  // input side
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_gap > 0) begin
        in_tvalid <= 0;
        in_gap--;
      end else if (pend_q.size() > 0) begin
        octet_t o;
        o = pend_q.pop_front();
        in_tdata <= o.octet;
        in_tlast <= o.eof;
        in_tvalid <= 1;
        in_gap = pick_gap();
      end else in_tvalid <= 0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 0;
      out_hold--;
    end else begin
      out_tready <= 1;
      out_hold = pick_gap();
    end
  end

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    in_fire <= in_tvalid && in_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == dhcpu_pkg::REG_OFFSET) m_off = cfg_data[0];
      else if (cfg_index == dhcpu_pkg::REG_USED) m_used = cfg_data[2:0];
      else if (cfg_index inside {[dhcpu_pkg::REG_PFX0 : dhcpu_pkg::REG_PFX3]})
        m_pfx[2'(cfg_index - dhcpu_pkg::REG_PFX0)] = cfg_data;
    end
    if (rst_n && in_tvalid && in_tready) predict_octet(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      report_t e;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
      end else begin
        e = report_q.pop_front();
        check_field("prefix_index", e.pidx, out_tdata[1:0]);
        check_field("allocated_count", e.count, out_tdata[32:2]);
        check_field("counted_now", e.counted, out_tdata[33]);
        check_field("alert_now", e.alert, out_tdata[34]);
        check_field("ack_seen", e.ack, out_tdata[35]);
        check_field("new_address", e.fresh, out_tdata[36]);
        check_field("given_address", e.given, out_tdata[68:37]);
        check_field("seen_table_full", e.full, out_tdata[69]);
        check_field("pad", 0, out_tdata[71:70]);
        check_field("last_result", e.last, out_tlast);
      end
    end
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [37:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || in_tvalid || report_q.size() > 0) @(negedge clk);
    // end-of-frame search may still run with no prefix in use
    repeat (1200) @(negedge clk);
  endtask

  task automatic add_opt(input logic [7:0] t, input int len);
    opt_buf.push_back(t);
    opt_buf.push_back(8'(len));
    repeat (len) opt_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // message-type option; up to two unrelated options ahead of it
  task automatic build_msg_opts(input logic [7:0] val, input bit zero_len);
    logic [7:0] t;
    opt_buf = {};
    repeat ($urandom_range(0, 2)) begin
      t = 8'($urandom_range(0, 255));
      if (t == dhcpu_pkg::OPT_MSG) t = 8'd1;
      add_opt(t, $urandom_range(0, 6));
    end
    opt_buf.push_back(dhcpu_pkg::OPT_MSG);
    opt_buf.push_back(zero_len ? 8'd0 : 8'd1);
    opt_buf.push_back(val);
    if ($urandom_range(0, 1)) opt_buf.push_back(8'd255);
  endtask

  task automatic add_frame(input logic [3:0] ver, input logic [3:0] ihl,
                           input logic [15:0] port, input logic [31:0] yi,
                           input logic [31:0] cookie, input int cut, input int tail);
    logic [7:0] fr [$];
    int x;
    octet_t o;
    x = (ihl == 0) ? 20 : ihl * 4;
    repeat (14 + 2 * m_off) fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back({ver, ihl});
    repeat (x - 1) fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(port[15:8]);
    fr.push_back(port[7:0]);
    repeat (22) fr.push_back(8'($urandom_range(0, 255)));
    for (int i = 3; i >= 0; i--) fr.push_back(yi[8*i +: 8]);
    repeat (216) fr.push_back(8'($urandom_range(0, 255)));
    for (int i = 3; i >= 0; i--) fr.push_back(cookie[8*i +: 8]);
    foreach (opt_buf[i]) fr.push_back(opt_buf[i]);
    repeat (tail) fr.push_back(8'($urandom_range(0, 255)));
    if (cut > 0 && cut < fr.size()) fr = fr[0:cut-1];
    foreach (fr[i]) begin
      o.octet = fr[i];
      o.eof = (i == fr.size() - 1);
      pend_q.push_back(o);
    end
  endtask

  task automatic add_ack(input logic [31:0] yi);
    build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
    add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, yi, dhcpu_pkg::COOKIE, 0, 0);
    acked.push_back(yi);
  endtask

  task automatic add_noise(input int len);
    octet_t o;
    for (int i = 0; i < len; i++) begin
      o.octet = 8'($urandom_range(0, 255));
      o.eof = (i == len - 1);
      pend_q.push_back(o);
    end
  endtask

  function automatic logic [31:0] pick_addr();
    int k, len;
    logic [31:0] mask;
    if (acked.size() > 0 && $urandom_range(0, 99) < 30)
      return acked[$urandom_range(0, acked.size() - 1)];
    k = $urandom_range(0, 3);
    len = int'(m_pfx[k][37:32]);
    if (len < 1 || len > 30) return $urandom;
    mask = (32'd1 << (32 - len)) - 1;
    return (m_pfx[k][31:0] & ~mask) | ($urandom & mask);
  endfunction

  task automatic random_frame();
    int r;
    logic [31:0] yi;
    r = $urandom_range(0, 99);
    yi = pick_addr();
    if (r < 65) begin
      build_msg_opts(dhcpu_pkg::MSG_ACK, $urandom_range(0, 9) == 0);
      add_frame(4'd4, $urandom_range(0, 9) ? 4'd5 : 4'($urandom_range(1, 15)),
                dhcpu_pkg::BOOTPS, yi, dhcpu_pkg::COOKIE, 0,
                $urandom_range(0, 3) ? 0 : $urandom_range(1, 20));
      acked.push_back(yi);
    end else if (r < 72) begin
      build_msg_opts(8'($urandom_range(0, 255)), 0);
      add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, yi, dhcpu_pkg::COOKIE, 0, 0);
    end else if (r < 79) begin
      build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
      add_frame(4'd4, 4'd5, 16'($urandom), yi, dhcpu_pkg::COOKIE, 0, 0);
    end else if (r < 85) begin
      build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
      add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, yi, $urandom, 0, 0);
    end else if (r < 92) begin
      build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
      add_frame(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                dhcpu_pkg::BOOTPS, yi, dhcpu_pkg::COOKIE, $urandom_range(1, 300), 0);
    end else add_noise($urandom_range(1, 60));
  endtask

  function automatic logic [37:0] random_prefix();
    logic [5:0] len;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return 38'd0;
    len = (r < 5) ? 6'($urandom_range(28, 30)) : (r < 8 ? 6'($urandom_range(1, 27))
                                                        : 6'($urandom_range(31, 63)));
    return {len, 8'd10, 8'd0, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 255))};
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    calm = 1;
    write_reg(dhcpu_pkg::REG_OFFSET, 38'd0);
    write_reg(dhcpu_pkg::REG_USED, 38'd4);
    write_reg(dhcpu_pkg::REG_PFX0, {6'd24, 32'h0A000000});
    write_reg(3'(dhcpu_pkg::REG_PFX0 + 1), {6'd30, 32'h0A000004});
    write_reg(3'(dhcpu_pkg::REG_PFX0 + 2), {6'd29, 32'h0A000008});
    write_reg(dhcpu_pkg::REG_PFX3, {6'd0, 32'h0A000000});
    add_ack(32'h0A000005);                     // alerts the /30 at once
    add_ack(32'h0A000005);                     // repeated address
    add_ack(32'h0A000000);                     // network host part
    add_ack(32'h0A0000FF);                     // broadcast host part
    build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
    add_frame(4'd6, 4'd5, dhcpu_pkg::BOOTPS, 32'h0A000009, dhcpu_pkg::COOKIE, 0, 0);
    add_frame(4'd4, 4'd0, dhcpu_pkg::BOOTPS, 32'h0A000009, dhcpu_pkg::COOKIE, 0, 0);
    add_frame(4'd4, 4'd5, 16'd68, 32'h0A000009, dhcpu_pkg::COOKIE, 0, 0);
    add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, 32'h0A000009, ~dhcpu_pkg::COOKIE, 0, 0);
    add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, 32'h0A000009, dhcpu_pkg::COOKIE,
              14 + 20 + 26, 0);
    opt_buf = {dhcpu_pkg::OPT_MSG, 8'd1};      // value byte never arrives
    add_frame(4'd4, 4'd5, dhcpu_pkg::BOOTPS, 32'h0A00000A, dhcpu_pkg::COOKIE, 0, 0);
    build_msg_opts(8'd6, 0);
    add_frame(4'd4, 4'd15, dhcpu_pkg::BOOTPS, 32'h0A00000A, dhcpu_pkg::COOKIE, 0, 0);
    build_msg_opts(dhcpu_pkg::MSG_ACK, 1);     // zero length, value still taken
    add_frame(4'd4, 4'd15, dhcpu_pkg::BOOTPS, 32'h0A00000A, dhcpu_pkg::COOKIE, 0, 0);
    add_ack(32'h0A000006);
    add_ack(32'hFFFFFFFF);
    add_ack(32'h00000000);
    add_noise(1);
    wait_idle();
    write_reg(dhcpu_pkg::REG_OFFSET, 38'd1);
    write_reg(dhcpu_pkg::REG_USED, 38'd7);
    write_reg(dhcpu_pkg::REG_PFX3, '1);
    add_ack(32'h0A00000C);
    add_ack(32'h0A00000D);
    wait_idle();
    write_reg(dhcpu_pkg::REG_USED, 38'd0);
    add_ack(32'h0A00000E);
    build_msg_opts(dhcpu_pkg::MSG_ACK, 0);
    add_frame(4'd4, 4'd5, 16'hFFFF, 32'h0A00000E, dhcpu_pkg::COOKIE, 0, 0);
    wait_idle();

    // random
    calm = 0;
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 1);
      write_reg(dhcpu_pkg::REG_OFFSET, 38'($urandom_range(0, 1)));
      write_reg(dhcpu_pkg::REG_USED, (ph == 3) ? 38'd0 : 38'($urandom_range(1, 7)));
      for (int k = 0; k < 4; k++)
        if ($urandom_range(0, 1) || ph == 0)
          write_reg(3'(dhcpu_pkg::REG_PFX0 + k), random_prefix());
      repeat (3) random_frame();
      wait_idle();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
hdl/dhcpu_pkg.sv
hdl/dhcp_ack_prefix_utilization.sv
hdl/dhcpu_checker.sv
sim/tb_dhcp_ack_prefix_utilization.sv
